### src/fbc_pkg.sv
// fbc_pkg: constants, types and helper functions for the feistel block cipher
// used by the interfaces, controller, datapath and top level; no dependencies
`default_nettype none

package fbc_pkg;

   localparam int unsigned NUM_ROUNDS = 16;
   localparam int unsigned RND_W      = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
   localparam logic [RND_W-1:0] RND_LAST = RND_W'(NUM_ROUNDS - 1);

   localparam int unsigned WORD_W = 64;
   localparam int unsigned HALF_W = 32;

   localparam logic [WORD_W-1:0] MUL_CONST = 64'h7FEF7FEF7FEF7FEF;
   localparam logic [WORD_W-1:0] KS_CONST  = 64'h123456789ABCDEF0;

   localparam int unsigned ROT_IN  = 7;
   localparam int unsigned ROT_KEY = 13;
   localparam int unsigned ROT_OUT = 17;
   localparam int unsigned ROT_KS0 = 11;
   localparam int unsigned ROT_KS1 = 23;

   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_CIPHER_KEY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IV_LEFT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IV_RIGHT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DIRECTION  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CHAINING   = 3'd4;

   typedef enum logic [1:0] {
      ST_KEYGEN,
      ST_IDLE,
      ST_ROUND,
      ST_FINISH
   } fsm_state_type;

   typedef enum logic [1:0] {
      PH_MIX,
      PH_MUL_LO,
      PH_MUL_HI,
      PH_MUL_X
   } phase_type;

   typedef struct packed {
      logic             req_ready;
      logic             kg_step;
      logic             round_en;
      phase_type        phase;
      logic [RND_W-1:0] idx;
      logic             out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic key_write;
      logic key_weak;
      logic out_free;
   } dp_status_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                              input int unsigned k);
      return (x << k) | (x >> (WORD_W - k));
   endfunction

endpackage

`default_nettype wire

### src/fbc_if.sv
// fbc_if: handshake channel interfaces for request, response and csr writes
// depends on fbc_pkg for field widths
`default_nettype none

interface fbc_req_if;
   import fbc_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] data_left;
   logic [WORD_W-1:0] data_right;
   logic              first_block;

   modport source (output valid, output data_left, output data_right,
                   output first_block, input ready);
   modport sink (input valid, input data_left, input data_right,
                 input first_block, output ready);
endinterface

interface fbc_rsp_if;
   import fbc_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] out_left;
   logic [WORD_W-1:0] out_right;
   logic              status;

   modport source (output valid, output out_left, output out_right,
                   output status, input ready);
   modport sink (input valid, input out_left, input out_right,
                 input status, output ready);
endinterface

interface fbc_csr_if;
   import fbc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [WORD_W-1:0]    wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

### src/fbc_ctrl.sv
// fbc_ctrl: sequencer for key schedule, feistel rounds and result hand-off
// depends on fbc_pkg; drives the datapath through ctrl_cmd_type
`default_nettype none

module fbc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  fbc_pkg::dp_status_type st,
   output fbc_pkg::ctrl_cmd_type  cmd
);
   import fbc_pkg::*;

   fsm_state_type    state_ff, state_in;
   logic [RND_W-1:0] cnt_ff, cnt_in;
   phase_type        ph_ff, ph_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_KEYGEN;
         cnt_ff   <= '0;
         ph_ff    <= PH_MIX;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ph_ff    <= ph_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ph_in        = ph_ff;
      cmd          = '0;
      cmd.phase    = ph_ff;
      cmd.idx      = cnt_ff;
      unique case (state_ff)
         ST_KEYGEN: begin
            cmd.kg_step = 1'b1;
            if (cnt_ff == RND_LAST) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            cmd.req_ready = !st.key_write;
            if (st.req_valid && !st.key_write) begin
               cnt_in = '0;
               ph_in  = PH_MIX;
               state_in = st.key_weak ? ST_FINISH : ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            unique case (ph_ff)
               PH_MIX:    ph_in = PH_MUL_LO;
               PH_MUL_LO: ph_in = PH_MUL_HI;
               PH_MUL_HI: ph_in = PH_MUL_X;
               PH_MUL_X: begin
                  ph_in = PH_MIX;
                  if (cnt_ff == RND_LAST) begin
                     state_in = ST_FINISH;
                     cnt_in   = '0;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               default: ph_in = PH_MIX;
            endcase
         end
         ST_FINISH: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (st.key_write) begin
         state_in = ST_KEYGEN;
         cnt_in   = '0;
         ph_in    = PH_MIX;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> st.out_free)
      else $error("result loaded while output register still occupied");

   assert property (@(posedge clock) disable iff (reset)
      st.req_valid && cmd.req_ready && !st.key_weak
      |=> state_ff == ST_ROUND && cnt_ff == '0 && ph_ff == PH_MIX)
      else $error("accepted item did not start at first round");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND && ph_ff == PH_MUL_X && cnt_ff == RND_LAST && !st.key_write
      |=> state_ff == ST_FINISH)
      else $error("last round did not hand off to finish");

   assert property (@(posedge clock) disable iff (reset)
      st.req_valid && cmd.req_ready |-> !cmd.round_en && !cmd.kg_step)
      else $error("item accepted while rounds or key schedule busy");

endmodule

`default_nettype wire

### src/fbc_datapath.sv
// fbc_datapath: csr registers, round key store, shared round unit, cbc chain
// and output register; depends on fbc_pkg and fbc_if, commanded by fbc_ctrl
`default_nettype none

module fbc_datapath (
   input  logic                  clock,
   input  logic                  reset,
   fbc_req_if.sink               req_chan,
   fbc_rsp_if.source             rsp_chan,
   fbc_csr_if.sink               csr_chan,
   input  fbc_pkg::ctrl_cmd_type cmd,
   output fbc_pkg::dp_status_type st
);
   import fbc_pkg::*;

   logic [WORD_W-1:0] key_ff, iv_l_ff, iv_r_ff;
   logic              dir_ff, cbc_ff;
   logic [WORD_W-1:0] kg_p_ff, kg_add_ff;
   logic [WORD_W-1:0] rk_ff [NUM_ROUNDS];
   logic [WORD_W-1:0] a_ff, b_ff, v_ff, acc_ff;
   logic [WORD_W-1:0] cin_l_ff, cin_r_ff;
   logic              item_dec_ff, item_cbc_ff, item_weak_ff;
   logic [WORD_W-1:0] chain_l_ff, chain_r_ff;
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] out_l_ff, out_r_ff;
   logic              out_st_ff;

   logic              csr_we, accept, key_weak, reload_chain;
   logic [WORD_W-1:0] kg_t, rk_sel, chain_l_eff, chain_r_eff;
   logic [WORD_W-1:0] res_l, res_r, mix_sum;
   logic [RND_W-1:0]  key_idx;
   logic [HALF_W-1:0] mul_a, mul_b;
   logic [WORD_W-1:0] prod;

   assign csr_chan.ready = 1'b1;
   assign csr_we         = csr_chan.valid;
   assign req_chan.ready = cmd.req_ready;
   assign accept         = req_chan.valid && cmd.req_ready;
   assign key_weak       = (key_ff == '0) || (key_ff == '1);

   assign st.req_valid = req_chan.valid;
   assign st.key_write = csr_we && (csr_chan.reg_index == REG_CIPHER_KEY);
   assign st.key_weak  = key_weak;
   assign st.out_free  = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_left  = out_l_ff;
   assign rsp_chan.out_right = out_r_ff;
   assign rsp_chan.status    = out_st_ff;

   // key schedule step
   assign kg_t = (rotl(kg_p_ff, ROT_KS0) ^ rotl(kg_p_ff, ROT_KS1)) + kg_add_ff;

   assign key_idx = item_dec_ff ? (RND_LAST - cmd.idx) : cmd.idx;
   assign rk_sel  = rk_ff[key_idx];

   assign reload_chain = cbc_ff && req_chan.first_block;
   assign chain_l_eff  = reload_chain ? iv_l_ff : chain_l_ff;
   assign chain_r_eff  = reload_chain ? iv_r_ff : chain_r_ff;

   // shared 32x32 multiplier for the 64-bit product mod 2^64
   always_comb begin
      unique case (cmd.phase)
         PH_MIX: begin
            mul_a = v_ff[HALF_W-1:0];
            mul_b = MUL_CONST[HALF_W-1:0];
         end
         PH_MUL_LO: begin
            mul_a = v_ff[HALF_W-1:0];
            mul_b = MUL_CONST[HALF_W-1:0];
         end
         PH_MUL_HI: begin
            mul_a = v_ff[WORD_W-1:HALF_W];
            mul_b = MUL_CONST[HALF_W-1:0];
         end
         PH_MUL_X: begin
            mul_a = v_ff[HALF_W-1:0];
            mul_b = MUL_CONST[WORD_W-1:HALF_W];
         end
         default: begin
            mul_a = v_ff[HALF_W-1:0];
            mul_b = MUL_CONST[HALF_W-1:0];
         end
      endcase
   end

   assign prod    = WORD_W'(mul_a) * WORD_W'(mul_b);
   assign mix_sum = {acc_ff[WORD_W-1:HALF_W] + prod[HALF_W-1:0], acc_ff[HALF_W-1:0]};

   // after the last round the halves swap
   assign res_l = b_ff;
   assign res_r = a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         iv_l_ff      <= '0;
         iv_r_ff      <= '0;
         dir_ff       <= 1'b0;
         cbc_ff       <= 1'b1;
         kg_p_ff      <= '0;
         kg_add_ff    <= '0;
         chain_l_ff   <= '0;
         chain_r_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (st.key_write) begin
            kg_p_ff   <= csr_chan.wdata;
            kg_add_ff <= '0;
         end else if (cmd.kg_step) begin
            kg_p_ff   <= kg_t;
            kg_add_ff <= kg_add_ff + KS_CONST;
         end
         if (csr_we) begin
            unique case (csr_chan.reg_index)
               REG_CIPHER_KEY: key_ff  <= csr_chan.wdata;
               REG_IV_LEFT:    iv_l_ff <= csr_chan.wdata;
               REG_IV_RIGHT:   iv_r_ff <= csr_chan.wdata;
               REG_DIRECTION:  dir_ff  <= csr_chan.wdata[0];
               REG_CHAINING:   cbc_ff  <= csr_chan.wdata[0];
               default: ;
            endcase
         end
         if (accept && !key_weak && reload_chain) begin
            chain_l_ff <= iv_l_ff;
            chain_r_ff <= iv_r_ff;
         end
         if (cmd.out_load && !item_weak_ff && item_cbc_ff) begin
            if (item_dec_ff) begin
               chain_l_ff <= cin_l_ff;
               chain_r_ff <= cin_r_ff;
            end else begin
               chain_l_ff <= res_l;
               chain_r_ff <= res_r;
            end
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.kg_step) begin
         rk_ff[cmd.idx] <= kg_t;
      end
      if (accept) begin
         item_dec_ff  <= dir_ff;
         item_cbc_ff  <= cbc_ff;
         item_weak_ff <= key_weak;
         cin_l_ff     <= req_chan.data_left;
         cin_r_ff     <= req_chan.data_right;
         if (cbc_ff && !dir_ff) begin
            a_ff <= req_chan.data_left ^ chain_l_eff;
            b_ff <= req_chan.data_right ^ chain_r_eff;
         end else begin
            a_ff <= req_chan.data_left;
            b_ff <= req_chan.data_right;
         end
      end else if (cmd.round_en) begin
         unique case (cmd.phase)
            PH_MIX:    v_ff <= rotl(rotl(b_ff, ROT_IN) ^ rk_sel, ROT_KEY);
            PH_MUL_LO: acc_ff <= prod;
            PH_MUL_HI: acc_ff[WORD_W-1:HALF_W] <= acc_ff[WORD_W-1:HALF_W] + prod[HALF_W-1:0];
            PH_MUL_X: begin
               a_ff <= b_ff;
               b_ff <= a_ff ^ rotl(mix_sum, ROT_OUT);
            end
            default: ;
         endcase
      end
      if (cmd.out_load) begin
         if (item_weak_ff) begin
            out_l_ff  <= '0;
            out_r_ff  <= '0;
            out_st_ff <= 1'b1;
         end else if (item_cbc_ff && item_dec_ff) begin
            out_l_ff  <= res_l ^ chain_l_ff;
            out_r_ff  <= res_r ^ chain_r_ff;
            out_st_ff <= 1'b0;
         end else begin
            out_l_ff  <= res_l;
            out_r_ff  <= res_r;
            out_st_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

### src/feistel_block_cipher_cbc.sv
// feistel_block_cipher_cbc: 128-bit feistel cipher, 64-bit key, ecb or cbc chaining
// each round is a mix step, then three passes of one shared 32x32 multiplier (mul_lo, mul_hi,
// mul_x); a weak key skips the rounds and gives a zero result with status set
// one item at a time: the next is taken only once the result is in the output register
// reset (sync, high) clears key, ivs, direction and chain and selects cbc, then the key schedule
// builds the NUM_ROUNDS round keys, as after every cipher_key write; no item is taken meanwhile
`default_nettype none

module feistel_block_cipher_cbc (
   input  logic      clock,
   input  logic      reset,
   fbc_req_if.sink   req_chan,
   fbc_rsp_if.source rsp_chan,
   fbc_csr_if.sink   csr_chan
);
   import fbc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type st;

   fbc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   fbc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .st       (st)
   );

endmodule

`default_nettype wire
